FILE: rtl/gtpie_pkg.sv
// Shared types, codes and element classification for the GTP IE stream decoder.
package gtpie_pkg;

  // Parser position within one information element
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LENH = 2'd1,
    PH_LENL = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // Result kinds as they leave the block
  typedef enum logic [3:0] {
    KIND_CAUSE    = 4'd0,
    KIND_IMSI     = 4'd1,
    KIND_TEID_D   = 4'd2,
    KIND_TEID_C   = 4'd3,
    KIND_NSAPI    = 4'd4,
    KIND_UE_ADDR  = 4'd5,
    KIND_APN_CHAR = 4'd6,
    KIND_GSN1     = 4'd7,
    KIND_GSN2     = 4'd8,
    KIND_MSISDN   = 4'd9,
    KIND_UNKNOWN  = 4'd10,
    KIND_ADDR_ERR = 4'd11,
    KIND_ADDR_NIL = 4'd12,
    KIND_REORDER  = 4'd13,
    KIND_MSG_END  = 4'd14
  } kind_t;

  // Element type numbers
  localparam logic [7:0] ET_CAUSE   = 8'd1;
  localparam logic [7:0] ET_IMSI    = 8'd2;
  localparam logic [7:0] ET_REORDER = 8'd8;
  localparam logic [7:0] ET_SKIP1   = 8'd15;
  localparam logic [7:0] ET_TEID_D  = 8'd16;
  localparam logic [7:0] ET_TEID_C  = 8'd17;
  localparam logic [7:0] ET_NSAPI   = 8'd20;
  localparam logic [7:0] ET_SKIP2   = 8'd26;
  localparam logic [7:0] ET_SKIP4   = 8'd127;
  localparam logic [7:0] ET_UE_ADDR = 8'd128;
  localparam logic [7:0] ET_APN     = 8'd131;
  localparam logic [7:0] ET_GSN     = 8'd133;
  localparam logic [7:0] ET_MSISDN  = 8'd134;
  localparam logic [7:0] ET_QOS     = 8'd135;

  localparam logic [15:0] UE_LEN_EMPTY = 16'd2;
  localparam logic [15:0] UE_LEN_IPV4  = 16'd6;
  localparam logic [7:0]  CHAR_DOT     = 8'd46;
  localparam logic [3:0]  BCD_FILLER   = 4'hf;

  typedef struct packed {
    logic       known;
    logic       len_prefixed;
    logic [3:0] fixed_len;
  } elem_class_t;

  // One queue entry: one or two result items from the same input item
  typedef struct packed {
    logic        two;
    kind_t       kind_a;
    logic [63:0] val_a;
    kind_t       kind_b;
    logic [63:0] val_b;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  function automatic elem_class_t classify(input logic [7:0] t);
    elem_class_t c;
    c = '{known: 1'b1, len_prefixed: 1'b0, fixed_len: 4'd0};
    case (t)
      ET_CAUSE, ET_REORDER, ET_SKIP1, ET_NSAPI: c.fixed_len = 4'd1;
      ET_SKIP2:                                  c.fixed_len = 4'd2;
      ET_TEID_D, ET_TEID_C, ET_SKIP4:            c.fixed_len = 4'd4;
      ET_GSN:                                    c.fixed_len = 4'd6;
      ET_IMSI:                                   c.fixed_len = 4'd8;
      ET_UE_ADDR, ET_APN, ET_MSISDN, ET_QOS:     c.len_prefixed = 1'b1;
      default:                                   c.known = 1'b0;
    endcase
    return c;
  endfunction

  // acc * 100 plus two BCD digits, low nibble first; filler adds zero
  function automatic logic [63:0] bcd_add(input logic [63:0] acc, input logic [7:0] b);
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [63:0] lo_term;
    logic [63:0] hi_term;
    lo = b[3:0];
    hi = b[7:4];
    lo_term = (lo == BCD_FILLER) ? 64'd0 : ({60'd0, lo} << 3) + ({60'd0, lo} << 1);
    hi_term = (hi == BCD_FILLER) ? 64'd0 : {60'd0, hi};
    return (acc << 6) + (acc << 5) + (acc << 2) + lo_term + hi_term;
  endfunction

endpackage

FILE: rtl/gtpie_front.sv
// Front part: walks the element layout byte by byte and forms queue entries.
module gtpie_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output gtpie_pkg::push_t   push
);

  gtpie_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]          etype_r, etype_nxt;
  logic [15:0]         elen_r, elen_nxt;
  logic [15:0]         bcnt_r, bcnt_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic                gsn_seen_r, gsn_seen_nxt;
  logic                discard_r, discard_nxt;

  gtpie_pkg::elem_class_t cls;
  logic                active;
  logic [15:0]         cnt_inc;
  logic                body_done;
  logic [15:0]         len_full;

  logic                fin_go;
  logic [63:0]         fin_acc;
  logic [15:0]         fin_len;
  logic                p_valid;
  gtpie_pkg::kind_t    p_kind;
  logic [63:0]         p_val;

  assign cls       = gtpie_pkg::classify(data_byte);
  assign active    = take & ~discard_r;
  assign cnt_inc   = bcnt_r + 16'd1;
  assign body_done = (cnt_inc >= elen_r);
  assign len_full  = {elen_r[15:8], data_byte};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (last_byte) begin
        phase_nxt = gtpie_pkg::PH_TYPE;
      end else if (!discard_r) begin
        case (phase_r)
          gtpie_pkg::PH_TYPE: begin
            if (!cls.known)            phase_nxt = gtpie_pkg::PH_TYPE;
            else if (cls.len_prefixed) phase_nxt = gtpie_pkg::PH_LENH;
            else                       phase_nxt = gtpie_pkg::PH_BODY;
          end
          gtpie_pkg::PH_LENH: phase_nxt = gtpie_pkg::PH_LENL;
          gtpie_pkg::PH_LENL: begin
            phase_nxt = (len_full == 16'd0) ? gtpie_pkg::PH_TYPE : gtpie_pkg::PH_BODY;
          end
          gtpie_pkg::PH_BODY: begin
            phase_nxt = body_done ? gtpie_pkg::PH_TYPE : gtpie_pkg::PH_BODY;
          end
          default: phase_nxt = gtpie_pkg::PH_TYPE;
        endcase
      end
    end
  end

  // Datapath updates and the result the byte itself causes
  always_comb begin
    etype_nxt    = etype_r;
    elen_nxt     = elen_r;
    bcnt_nxt     = bcnt_r;
    acc_nxt      = acc_r;
    gsn_seen_nxt = gsn_seen_r;
    discard_nxt  = discard_r;
    fin_go       = 1'b0;
    fin_acc      = acc_r;
    fin_len      = elen_r;
    p_valid      = 1'b0;
    p_kind       = gtpie_pkg::KIND_CAUSE;
    p_val        = 64'd0;

    if (active) begin
      case (phase_r)
        gtpie_pkg::PH_TYPE: begin
          etype_nxt = data_byte;
          elen_nxt  = {12'd0, cls.fixed_len};
          bcnt_nxt  = 16'd0;
          acc_nxt   = 64'd0;
          if (!cls.known) begin
            p_valid     = 1'b1;
            p_kind      = gtpie_pkg::KIND_UNKNOWN;
            p_val       = {56'd0, data_byte};
            discard_nxt = 1'b1;
          end
        end
        gtpie_pkg::PH_LENH: begin
          elen_nxt = {data_byte, 8'h00};
        end
        gtpie_pkg::PH_LENL: begin
          elen_nxt = len_full;
          bcnt_nxt = 16'd0;
          acc_nxt  = 64'd0;
          fin_go   = (len_full == 16'd0);
          fin_acc  = 64'd0;
          fin_len  = len_full;
        end
        gtpie_pkg::PH_BODY: begin
          if (etype_r == gtpie_pkg::ET_APN) begin
            if (acc_r == 64'd0) begin
              // label length byte: a dot between labels
              if (bcnt_r != 16'd0) begin
                p_valid = 1'b1;
                p_kind  = gtpie_pkg::KIND_APN_CHAR;
                p_val   = {56'd0, gtpie_pkg::CHAR_DOT};
              end
              acc_nxt = {56'd0, data_byte};
            end else begin
              p_valid = 1'b1;
              p_kind  = gtpie_pkg::KIND_APN_CHAR;
              p_val   = {56'd0, data_byte};
              acc_nxt = acc_r - 64'd1;
            end
          end else if (etype_r == gtpie_pkg::ET_IMSI) begin
            acc_nxt = gtpie_pkg::bcd_add(acc_r, data_byte);
          end else if (etype_r == gtpie_pkg::ET_MSISDN) begin
            if (bcnt_r != 16'd0) acc_nxt = gtpie_pkg::bcd_add(acc_r, data_byte);
          end else begin
            acc_nxt = {acc_r[55:0], data_byte};
          end
          bcnt_nxt = cnt_inc;
          fin_go   = body_done;
          fin_acc  = acc_nxt;
          fin_len  = elen_r;
        end
        default: ;
      endcase

      if (fin_go) begin
        case (etype_r)
          gtpie_pkg::ET_CAUSE: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_CAUSE;
            p_val = {56'd0, fin_acc[7:0]};
          end
          gtpie_pkg::ET_IMSI: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_IMSI; p_val = fin_acc;
          end
          gtpie_pkg::ET_REORDER: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_REORDER;
            p_val = {63'd0, fin_acc[0]};
          end
          gtpie_pkg::ET_TEID_D: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_TEID_D;
            p_val = {32'd0, fin_acc[31:0]};
          end
          gtpie_pkg::ET_TEID_C: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_TEID_C;
            p_val = {32'd0, fin_acc[31:0]};
          end
          gtpie_pkg::ET_NSAPI: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_NSAPI;
            p_val = {56'd0, fin_acc[7:0]};
          end
          gtpie_pkg::ET_UE_ADDR: begin
            p_valid = 1'b1;
            if (fin_len == gtpie_pkg::UE_LEN_EMPTY) begin
              p_kind = gtpie_pkg::KIND_ADDR_NIL; p_val = 64'd0;
            end else if (fin_len != gtpie_pkg::UE_LEN_IPV4) begin
              p_kind = gtpie_pkg::KIND_ADDR_ERR; p_val = {48'd0, fin_len};
            end else begin
              p_kind = gtpie_pkg::KIND_UE_ADDR; p_val = {32'd0, fin_acc[31:0]};
            end
          end
          gtpie_pkg::ET_GSN: begin
            p_valid = 1'b1;
            p_kind  = gsn_seen_r ? gtpie_pkg::KIND_GSN2 : gtpie_pkg::KIND_GSN1;
            p_val   = {32'd0, fin_acc[31:0]};
            gsn_seen_nxt = 1'b1;
          end
          gtpie_pkg::ET_MSISDN: begin
            p_valid = 1'b1; p_kind = gtpie_pkg::KIND_MSISDN; p_val = fin_acc;
          end
          default: ;
        endcase
      end
    end

    // final byte: drop any open element, return to the start of a message
    if (take && last_byte) begin
      etype_nxt    = 8'd0;
      elen_nxt     = 16'd0;
      bcnt_nxt     = 16'd0;
      acc_nxt      = 64'd0;
      gsn_seen_nxt = 1'b0;
      discard_nxt  = 1'b0;
    end
  end

  // Queue entry: the byte's own result first, then message end
  always_comb begin
    push.valid        = take & (p_valid | last_byte);
    push.entry.two    = p_valid & last_byte;
    push.entry.kind_a = p_valid ? p_kind : gtpie_pkg::KIND_MSG_END;
    push.entry.val_a  = p_valid ? p_val : 64'd0;
    push.entry.kind_b = gtpie_pkg::KIND_MSG_END;
    push.entry.val_b  = 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= gtpie_pkg::PH_TYPE;
      etype_r    <= 8'd0;
      elen_r     <= 16'd0;
      bcnt_r     <= 16'd0;
      acc_r      <= 64'd0;
      gsn_seen_r <= 1'b0;
      discard_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      etype_r    <= etype_nxt;
      elen_r     <= elen_nxt;
      bcnt_r     <= bcnt_nxt;
      acc_r      <= acc_nxt;
      gsn_seen_r <= gsn_seen_nxt;
      discard_r  <= discard_nxt;
    end
  end

endmodule

FILE: rtl/gtpie_queue.sv
// Back part: entry queue that hands out one result item per cycle while out_ready is high.
module gtpie_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gtpie_pkg::push_t  push,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_kind,
  output logic [63:0]       out_value,
  output logic              out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gtpie_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              half_r, half_nxt;
  gtpie_pkg::entry_t head;
  logic              slot_take;
  logic              pop;
  logic              wr;

  assign head      = mem_r[rd_ptr_r];
  assign full      = (count_r == FULL_CNT);
  assign out_valid = (count_r != '0);
  assign out_kind  = half_r ? head.kind_b : head.kind_a;
  assign out_value = half_r ? head.val_b : head.val_a;
  assign out_last  = half_r | ~head.two;

  assign slot_take = out_valid & out_ready;
  assign pop       = slot_take & out_last;
  assign wr        = push.valid & ~full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    half_nxt   = half_r;
    if (wr) wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    if (slot_take) half_nxt = ~out_last;
    if (pop) rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    case ({wr, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      half_r   <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      half_r   <= half_nxt;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= push.entry;
  end

endmodule

FILE: rtl/gtp_ie_stream_decoder.sv
// Top level of the GTPv1-C information-element stream decoder.
//
// Usage:
//   Input channel (in_*): one byte of the message's information-element area
//   per item; in_tlast marks the final byte of the message. Result channel
//   (out_*): decoded fields; out_tuser carries the field kind, out_tdata the
//   64-bit value, out_tlast flags the last result caused by one input byte.
//   Each byte causes zero, one or two results; the final byte always yields
//   a message-end result, after any result of its own.
//   Results leave the entry queue in order. Throughput: one byte per cycle
//   while the queue has room; the queue drains one result per cycle while
//   out_tready is high, so a stretch of bytes that each cause two results
//   drains at half rate. The parser updates its state per byte; the queue of
//   QUEUE_DEPTH entries (at least 2) lets the parser run on while results
//   wait. in_tready drops only when that queue is full, so a stalled
//   receiver backs up into the input once the queue has filled.
//   Reset (rst_n low, synchronous) empties the queue and puts the parser at
//   the start of a message. No clearing pass is needed.
module gtp_ie_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] field_value
  output logic [3:0]  out_tuser,  // [3:0] field_kind
  output logic        out_tlast   // last_result
);

  gtpie_pkg::push_t push;
  logic             q_full;
  logic             take;

  // Accept a byte whenever the queue has room for its entry
  assign in_tready = ~q_full;
  assign take      = in_tvalid & in_tready;

  gtpie_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push)
  );

  gtpie_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_value (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

FILE: tb/gtpie_field_checker.sv
// Field checker for the GTP IE stream decoder: decodes each byte and checks every result.
`timescale 1ns / 100ps

module gtpie_field_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [63:0] field_value
  input  logic [3:0]  out_tuser,  // [3:0] field_kind
  input  logic        out_tlast,  // last_result
  output int          mismatches,
  output int          pending,
  output int          checked
);

  typedef struct {
    gtpie_pkg::kind_t kind;
    logic [63:0]      value;
    logic             last;
  } field_t;

  field_t field_q[$];
  field_t byte_results[3];
  int     n_byte_results;
  int     err_cnt;
  int     seen_cnt;

  // Shadow copy of the parser state
  gtpie_pkg::phase_t ph;
  logic [7:0]        cur_type;
  logic [15:0]       cur_len;
  logic [15:0]       cur_count;
  logic [63:0]       acc;
  logic              gsn_done;
  logic              skip_msg;

  function automatic logic [63:0] dec2(input logic [63:0] a, input logic [7:0] b);
    logic [63:0] r;
    r = a * 64'd100;
    if (b[3:0] != gtpie_pkg::BCD_FILLER) r = r + {60'd0, b[3:0]} * 64'd10;
    if (b[7:4] != gtpie_pkg::BCD_FILLER) r = r + {60'd0, b[7:4]};
    return r;
  endfunction

  task automatic clear_parser();
    ph        = gtpie_pkg::PH_TYPE;
    cur_type  = 8'd0;
    cur_len   = 16'd0;
    cur_count = 16'd0;
    acc       = 64'd0;
    gsn_done  = 1'b0;
    skip_msg  = 1'b0;
  endtask

  // Append a result; only the newest one of a byte carries the last flag
  task automatic note(input gtpie_pkg::kind_t k, input logic [63:0] v);
    if (n_byte_results > 0) byte_results[n_byte_results - 1].last = 1'b0;
    byte_results[n_byte_results] = '{k, v, 1'b1};
    n_byte_results++;
  endtask

  task automatic close_element();
    case (cur_type)
      gtpie_pkg::ET_CAUSE:   note(gtpie_pkg::KIND_CAUSE, {56'd0, acc[7:0]});
      gtpie_pkg::ET_IMSI:    note(gtpie_pkg::KIND_IMSI, acc);
      gtpie_pkg::ET_REORDER: note(gtpie_pkg::KIND_REORDER, {63'd0, acc[0]});
      gtpie_pkg::ET_TEID_D:  note(gtpie_pkg::KIND_TEID_D, {32'd0, acc[31:0]});
      gtpie_pkg::ET_TEID_C:  note(gtpie_pkg::KIND_TEID_C, {32'd0, acc[31:0]});
      gtpie_pkg::ET_NSAPI:   note(gtpie_pkg::KIND_NSAPI, {56'd0, acc[7:0]});
      gtpie_pkg::ET_UE_ADDR: begin
        if (cur_len == gtpie_pkg::UE_LEN_EMPTY) begin
          note(gtpie_pkg::KIND_ADDR_NIL, 64'd0);
        end else if (cur_len != gtpie_pkg::UE_LEN_IPV4) begin
          note(gtpie_pkg::KIND_ADDR_ERR, {48'd0, cur_len});
        end else begin
          note(gtpie_pkg::KIND_UE_ADDR, {32'd0, acc[31:0]});
        end
      end
      gtpie_pkg::ET_GSN: begin
        note(gsn_done ? gtpie_pkg::KIND_GSN2 : gtpie_pkg::KIND_GSN1, {32'd0, acc[31:0]});
        gsn_done = 1'b1;
      end
      gtpie_pkg::ET_MSISDN:  note(gtpie_pkg::KIND_MSISDN, acc);
      default: ;
    endcase
    ph = gtpie_pkg::PH_TYPE;
  endtask

  task automatic open_element(input logic [7:0] t);
    cur_type  = t;
    cur_len   = 16'd0;
    cur_count = 16'd0;
    acc       = 64'd0;
    ph        = gtpie_pkg::PH_BODY;
    case (t)
      gtpie_pkg::ET_CAUSE, gtpie_pkg::ET_REORDER,
      gtpie_pkg::ET_SKIP1, gtpie_pkg::ET_NSAPI:   cur_len = 16'd1;
      gtpie_pkg::ET_SKIP2:                        cur_len = 16'd2;
      gtpie_pkg::ET_TEID_D, gtpie_pkg::ET_TEID_C,
      gtpie_pkg::ET_SKIP4:                        cur_len = 16'd4;
      gtpie_pkg::ET_GSN:                          cur_len = 16'd6;
      gtpie_pkg::ET_IMSI:                         cur_len = 16'd8;
      gtpie_pkg::ET_UE_ADDR, gtpie_pkg::ET_APN,
      gtpie_pkg::ET_MSISDN, gtpie_pkg::ET_QOS:    ph = gtpie_pkg::PH_LENH;
      default: begin
        // unknown type: report it and ignore the rest of the message
        note(gtpie_pkg::KIND_UNKNOWN, {56'd0, t});
        skip_msg = 1'b1;
        ph = gtpie_pkg::PH_TYPE;
      end
    endcase
  endtask

  task automatic body_byte(input logic [7:0] b);
    if (cur_type == gtpie_pkg::ET_APN) begin
      if (acc == 64'd0) begin
        // label length: a dot, except for the first label
        if (cur_count != 16'd0) note(gtpie_pkg::KIND_APN_CHAR, {56'd0, gtpie_pkg::CHAR_DOT});
        acc = {56'd0, b};
      end else begin
        note(gtpie_pkg::KIND_APN_CHAR, {56'd0, b});
        acc = acc - 64'd1;
      end
    end else if (cur_type == gtpie_pkg::ET_IMSI) begin
      acc = dec2(acc, b);
    end else if (cur_type == gtpie_pkg::ET_MSISDN) begin
      if (cur_count != 16'd0) acc = dec2(acc, b);
    end else begin
      acc = {acc[55:0], b};
    end
    cur_count = cur_count + 16'd1;
    if (cur_count >= cur_len) close_element();
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    n_byte_results = 0;
    if (!skip_msg) begin
      case (ph)
        gtpie_pkg::PH_TYPE: open_element(b);
        gtpie_pkg::PH_LENH: begin
          cur_len = {b, 8'd0};
          ph = gtpie_pkg::PH_LENL;
        end
        gtpie_pkg::PH_LENL: begin
          cur_len   = cur_len | {8'd0, b};
          cur_count = 16'd0;
          acc       = 64'd0;
          if (cur_len == 16'd0) close_element();
          else ph = gtpie_pkg::PH_BODY;
        end
        default: body_byte(b);
      endcase
    end
    if (last) begin
      note(gtpie_pkg::KIND_MSG_END, 64'd0);
      clear_parser();
    end
    for (int i = 0; i < n_byte_results; i++) field_q.push_back(byte_results[i]);
  endtask

  task automatic compare_field();
    field_t e;
    seen_cnt++;
    if (field_q.size() == 0) begin
      $error("unexpected result: field_kind %0d field_value 0x%0h", out_tuser, out_tdata);
      err_cnt++;
    end else begin
      e = field_q.pop_front();
      if (out_tuser !== e.kind) begin
        $error("field_kind: expected %0d, actual %0d", e.kind, out_tuser);
        err_cnt++;
      end
      if (out_tdata !== e.value) begin
        $error("field_value: expected 0x%0h, actual 0x%0h", e.value, out_tdata);
        err_cnt++;
      end
      if (out_tlast !== e.last) begin
        $error("last_result: expected %0b, actual %0b", e.last, out_tlast);
        err_cnt++;
      end
    end
  endtask

  initial begin
    err_cnt  = 0;
    seen_cnt = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      field_q.delete();
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) compare_field();
    end
    mismatches <= err_cnt;
    pending    <= field_q.size();
    checked    <= seen_cnt;
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives GTP IE messages into the decoder and reports the verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 350;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] field_value
  logic [3:0]  out_tuser;  // [3:0] field_kind
  logic        out_tlast;  // last_result

  int mismatches;
  int pending;
  int checked;

  // Stimulus knobs and counters; recv_idle_pct and hold_requests are shared with the receiver process
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int bytes_sent;
  int msgs_sent;
  int cycle_count;

  logic [7:0] msg[$];

  gtp_ie_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  gtpie_field_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request so that the
  // result queue fills and the decoder has to drop in_tready.
  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return b;
  endfunction

  // Mostly proper BCD digits, some with a filler nibble, some any byte at all
  function automatic logic [7:0] rand_bcd();
    logic [3:0] lo;
    logic [3:0] hi;
    lo = 4'($urandom_range(9));
    hi = 4'($urandom_range(9));
    case ($urandom_range(9))
      0: hi = gtpie_pkg::BCD_FILLER;
      1: return rand_byte();
      default: ;
    endcase
    return {hi, lo};
  endfunction

  // Offer one item; hold it until the decoder takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    msgs_sent++;
  endtask

  task automatic put_head(input logic [7:0] t, input logic [15:0] len);
    msg.push_back(t);
    msg.push_back(len[15:8]);
    msg.push_back(len[7:0]);
  endtask

  // Append one element with random content; some are unknown types or have odd lengths
  task automatic add_element();
    logic [7:0]  t;
    logic [7:0]  lab;
    logic [7:0]  apn[$];
    logic [15:0] len;
    bit          known;
    case ($urandom_range(15))
      0: begin msg.push_back(gtpie_pkg::ET_CAUSE);   msg.push_back(rand_byte()); end
      1: begin msg.push_back(gtpie_pkg::ET_REORDER); msg.push_back(rand_byte()); end
      2: begin msg.push_back(gtpie_pkg::ET_SKIP1);   msg.push_back(rand_byte()); end
      3: begin msg.push_back(gtpie_pkg::ET_NSAPI);   msg.push_back(rand_byte()); end
      4: begin
        msg.push_back(gtpie_pkg::ET_SKIP2);
        repeat (2) msg.push_back(rand_byte());
      end
      5, 6, 7: begin
        t = ($urandom_range(2) == 0) ? gtpie_pkg::ET_TEID_D :
            ($urandom_range(1) ? gtpie_pkg::ET_TEID_C : gtpie_pkg::ET_SKIP4);
        msg.push_back(t);
        repeat (4) msg.push_back(rand_byte());
      end
      8: begin
        msg.push_back(gtpie_pkg::ET_GSN);
        repeat (6) msg.push_back(rand_byte());
      end
      9: begin
        msg.push_back(gtpie_pkg::ET_IMSI);
        repeat (8) msg.push_back(rand_bcd());
      end
      10: begin
        // favour the empty and IPv4 lengths, but keep odd ones coming
        case ($urandom_range(3))
          0: len = gtpie_pkg::UE_LEN_EMPTY;
          1, 2: len = gtpie_pkg::UE_LEN_IPV4;
          default: len = 16'($urandom_range(9));
        endcase
        put_head(gtpie_pkg::ET_UE_ADDR, len);
        repeat (len) msg.push_back(rand_byte());
      end
      11, 12: begin
        repeat ($urandom_range(1, 3)) begin
          lab = 8'($urandom_range(5));
          apn.push_back(lab);
          repeat (lab) begin
            t = 8'($urandom_range(8'h61, 8'h7a));
            apn.push_back(t);
          end
        end
        // sometimes let the length cut a label or run into the next element
        len = 16'(apn.size());
        if ($urandom_range(3) == 0) len = 16'($urandom_range(apn.size() + 2));
        put_head(gtpie_pkg::ET_APN, len);
        for (int i = 0; i < len && i < apn.size(); i++) msg.push_back(apn[i]);
      end
      13: begin
        len = 16'($urandom_range(9));
        put_head(gtpie_pkg::ET_MSISDN, len);
        if (len != 0) msg.push_back(rand_byte());
        repeat (len > 0 ? len - 1 : 0) msg.push_back(rand_bcd());
      end
      14: begin
        len = 16'($urandom_range(12));
        put_head(gtpie_pkg::ET_QOS, len);
        repeat (len) msg.push_back(rand_byte());
      end
      default: begin
        do begin
          t = rand_byte();
          case (t)
            gtpie_pkg::ET_CAUSE, gtpie_pkg::ET_IMSI, gtpie_pkg::ET_REORDER,
            gtpie_pkg::ET_SKIP1, gtpie_pkg::ET_TEID_D, gtpie_pkg::ET_TEID_C,
            gtpie_pkg::ET_NSAPI, gtpie_pkg::ET_SKIP2, gtpie_pkg::ET_SKIP4,
            gtpie_pkg::ET_UE_ADDR, gtpie_pkg::ET_APN, gtpie_pkg::ET_GSN,
            gtpie_pkg::ET_MSISDN, gtpie_pkg::ET_QOS: known = 1'b1;
            default: known = 1'b0;
          endcase
        end while (known);
        msg.push_back(t);
        repeat ($urandom_range(3)) msg.push_back(rand_byte());
      end
    endcase
  endtask

  task automatic build_msg();
    logic [7:0]  t;
    logic [15:0] len;
    int          keep;
    msg.delete();
    repeat ($urandom_range(1, 5)) add_element();
    // a huge length-prefixed element that the message end cuts short
    if ($urandom_range(11) == 0) begin
      case ($urandom_range(3))
        0: t = gtpie_pkg::ET_UE_ADDR;
        1: t = gtpie_pkg::ET_APN;
        2: t = gtpie_pkg::ET_MSISDN;
        default: t = gtpie_pkg::ET_QOS;
      endcase
      len = {rand_byte() | 8'h80, rand_byte()};
      put_head(t, len);
      repeat ($urandom_range(6)) msg.push_back(rand_byte());
    end
    // truncate at a random point
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(1, msg.size());
      while (msg.size() > keep) void'(msg.pop_back());
    end
    // pure noise now and then
    if ($urandom_range(19) == 0) begin
      msg.delete();
      repeat ($urandom_range(1, 8)) msg.push_back(rand_byte());
    end
  endtask

  task automatic run_phase(input int s_pct, input int r_pct);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) begin
      build_msg();
      send_msg();
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    bytes_sent    = 0;
    msgs_sent     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    in_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed messages, light idling on both sides
    send_idle_pct = 20;
    recv_idle_pct = 20;
    // cause, reordering with all bits set, NSAPI ending on the last byte
    msg = {gtpie_pkg::ET_CAUSE, 8'd128, gtpie_pkg::ET_REORDER, 8'hff,
           gtpie_pkg::ET_NSAPI, 8'h05};
    send_msg();
    // TEID extremes
    msg = {gtpie_pkg::ET_TEID_D, 8'hff, 8'hff, 8'hff, 8'hff,
           gtpie_pkg::ET_TEID_C, 8'h00, 8'h00, 8'h00, 8'h00};
    send_msg();
    // IMSI with filler nibbles and nibbles above nine
    msg = {gtpie_pkg::ET_IMSI, 8'h21, 8'h43, 8'hf5, 8'h5f, 8'hff, 8'hab, 8'hce, 8'h09};
    send_msg();
    // MSISDN long enough for the value to wrap
    msg = {gtpie_pkg::ET_MSISDN, 8'h00, 8'd12, 8'h91};
    repeat (11) msg.push_back(8'h99);
    send_msg();
    // MSISDN with zero length and with only the skipped byte
    msg = {gtpie_pkg::ET_MSISDN, 8'h00, 8'h00, gtpie_pkg::ET_MSISDN, 8'h00, 8'h01, 8'h91};
    send_msg();
    // end-user address: empty, IPv4, zero length, odd length
    msg = {gtpie_pkg::ET_UE_ADDR, 8'h00, 8'h02, 8'hf1, 8'h21,
           gtpie_pkg::ET_UE_ADDR, 8'h00, 8'h06, 8'hf1, 8'h21, 8'd10, 8'd0, 8'd0, 8'd1,
           gtpie_pkg::ET_UE_ADDR, 8'h00, 8'h00,
           gtpie_pkg::ET_UE_ADDR, 8'h00, 8'h03, 8'd1, 8'd2, 8'd3};
    send_msg();
    // APN with an empty label and a label cut by the length
    msg = {gtpie_pkg::ET_APN, 8'h00, 8'd9, 8'd3, 8'h61, 8'h62, 8'h63, 8'd0, 8'd5,
           8'h78, 8'h79, 8'h7a};
    send_msg();
    // skipped elements, two GSN addresses, QoS
    msg = {gtpie_pkg::ET_SKIP1, 8'd7, gtpie_pkg::ET_SKIP2, 8'd1, 8'd2,
           gtpie_pkg::ET_SKIP4, 8'd1, 8'd2, 8'd3, 8'd4,
           gtpie_pkg::ET_GSN, 8'd0, 8'd4, 8'd192, 8'd168, 8'd0, 8'd1,
           gtpie_pkg::ET_GSN, 8'd0, 8'd4, 8'd10, 8'd0, 8'd0, 8'd2,
           gtpie_pkg::ET_QOS, 8'h00, 8'h03, 8'd1, 8'd2, 8'd3};
    send_msg();
    // a new message starts again with the first GSN kind
    msg = {gtpie_pkg::ET_GSN, 8'd0, 8'd4, 8'd1, 8'd2, 8'd3, 8'd4};
    send_msg();
    // unknown type: the rest of the message is ignored
    msg = {8'd3, gtpie_pkg::ET_CAUSE, 8'd5, 8'd255};
    send_msg();
    msg = {8'd0};
    send_msg();
    msg = {8'd255, gtpie_pkg::ET_CAUSE};
    send_msg();
    // truncation in the body, on the type byte, in the length, deep in an APN
    msg = {gtpie_pkg::ET_TEID_D, 8'd1, 8'd2};
    send_msg();
    msg = {gtpie_pkg::ET_APN};
    send_msg();
    msg = {gtpie_pkg::ET_UE_ADDR, 8'hff};
    send_msg();
    msg = {gtpie_pkg::ET_APN, 8'hff, 8'hff, 8'd2, 8'h41, 8'h42};
    send_msg();

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    run_phase(28, 51);
    run_phase(51, 28);
    // receiver holds off for a long stretch while the sender keeps offering
    hold_requests++;
    run_phase(0, 0);
    in_tvalid <= 1'b0;

    // Drain: wait for every expected result to be checked before the verdict
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d messages; %0d results compared", bytes_sent, msgs_sent,
             checked);
    $display("Covered all element types, truncation, unknown types and a long back-pressure");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: gtp_ie_stream_decoder.f
rtl/gtpie_pkg.sv
rtl/gtpie_front.sv
rtl/gtpie_queue.sv
rtl/gtp_ie_stream_decoder.sv
tb/gtpie_field_checker.sv
tb/tb_top.sv
